### rtl/complex_arithmetic_unit_defines.svh
// assertion macros for the complex arithmetic unit
// included by the modules that check their own logic, no other dependencies
`ifndef COMPLEX_ARITHMETIC_UNIT_DEFINES_SVH
`define COMPLEX_ARITHMETIC_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define CAU_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define CAU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define CAU_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define CAU_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

### rtl/cau_pkg.sv
// shared types and constants of the complex arithmetic unit
// no dependencies
package cau_pkg;

    localparam int DATA_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF  = 16;
    localparam int OP_W           = 4;
    localparam int STATUS_W       = 2;
    localparam int NUM_MUL        = 6;
    localparam int QUEUE_DEPTH    = 2;

    typedef enum logic [OP_W-1:0] {
        OP_ADD     = 4'd0,
        OP_SUB     = 4'd1,
        OP_MUL     = 4'd2,
        OP_DIV     = 4'd3,
        OP_INV     = 4'd4,
        OP_CONJ    = 4'd5,
        OP_NEG     = 4'd6,
        OP_MULREAL = 4'd7,
        OP_MULIMAG = 4'd8,
        OP_DIVREAL = 4'd9,
        OP_DIVIMAG = 4'd10
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK  = 2'd0,
        ST_DZ  = 2'd1,
        ST_SAT = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        SH_NONE = 2'd0,
        SH_FB   = 2'd1,
        SH_2FB  = 2'd2
    } shift_t;

    // neg: sign of each product term in the two sums
    typedef struct packed {
        logic       is_div;
        shift_t     shift;
        logic [3:0] neg;
    } cls_t;

endpackage

### rtl/cau_if.sv
// request and response channel interfaces of the complex arithmetic unit
// depends on cau_pkg
interface cau_req_if #(
    parameter int DATA_WIDTH = cau_pkg::DATA_WIDTH_DEF
);
    logic                          valid;
    logic                          ready;
    logic [cau_pkg::OP_W-1:0]      req_type;
    logic signed [DATA_WIDTH-1:0]  a_re;
    logic signed [DATA_WIDTH-1:0]  a_im;
    logic signed [DATA_WIDTH-1:0]  b_re;
    logic signed [DATA_WIDTH-1:0]  b_im;

    modport source (output valid, req_type, a_re, a_im, b_re, b_im, input ready);
    modport sink   (input valid, req_type, a_re, a_im, b_re, b_im, output ready);
endinterface

interface cau_rsp_if #(
    parameter int DATA_WIDTH = cau_pkg::DATA_WIDTH_DEF
);
    logic                          valid;
    logic                          ready;
    logic signed [DATA_WIDTH-1:0]  res_re;
    logic signed [DATA_WIDTH-1:0]  res_im;
    logic [cau_pkg::STATUS_W-1:0]  status;

    modport source (output valid, res_re, res_im, status, input ready);
    modport sink   (input valid, res_re, res_im, status, output ready);
endinterface

### rtl/cau_front.sv
// front end: accepts requests and routes operands onto the six multipliers
// depends on cau_pkg and cau_if
module cau_front #(
    parameter int DATA_WIDTH = cau_pkg::DATA_WIDTH_DEF
) (
    cau_req_if.sink                       req,
    input  logic                          q_full,
    output logic                          push,
    output cau_pkg::cls_t                 cls,
    output logic signed [DATA_WIDTH-1:0]  mul_x [cau_pkg::NUM_MUL],
    output logic signed [DATA_WIDTH-1:0]  mul_y [cau_pkg::NUM_MUL]
);
    import cau_pkg::*;

    localparam logic signed [DATA_WIDTH-1:0] ONE = {{(DATA_WIDTH-1){1'b0}}, 1'b1};

    assign req.ready = !q_full;
    assign push      = req.valid && !q_full;

    always_comb
    begin
        cls.is_div = 1'b0;
        cls.shift  = SH_NONE;
        cls.neg    = 4'b0000;
        for (int k = 0; k < NUM_MUL; k++)
        begin
            mul_x[k] = '0;
            mul_y[k] = '0;
        end
        unique case (req.req_type) inside
            OP_ADD, OP_SUB:
            begin
                mul_x[0] = req.a_re; mul_y[0] = ONE;
                mul_x[1] = req.b_re; mul_y[1] = ONE;
                mul_x[2] = req.a_im; mul_y[2] = ONE;
                mul_x[3] = req.b_im; mul_y[3] = ONE;
                if (req.req_type == OP_SUB)
                begin
                    cls.neg = 4'b1010;
                end
            end
            OP_MUL:
            begin
                mul_x[0] = req.a_re; mul_y[0] = req.b_re;
                mul_x[1] = req.a_im; mul_y[1] = req.b_im;
                mul_x[2] = req.a_re; mul_y[2] = req.b_im;
                mul_x[3] = req.a_im; mul_y[3] = req.b_re;
                cls.neg   = 4'b0010;
                cls.shift = SH_FB;
            end
            OP_DIV:
            begin
                mul_x[0] = req.a_re; mul_y[0] = req.b_re;
                mul_x[1] = req.a_im; mul_y[1] = req.b_im;
                mul_x[2] = req.a_im; mul_y[2] = req.b_re;
                mul_x[3] = req.a_re; mul_y[3] = req.b_im;
                mul_x[4] = req.b_re; mul_y[4] = req.b_re;
                mul_x[5] = req.b_im; mul_y[5] = req.b_im;
                cls.neg    = 4'b1000;
                cls.shift  = SH_FB;
                cls.is_div = 1'b1;
            end
            OP_INV:
            begin
                mul_x[0] = req.a_re; mul_y[0] = ONE;
                mul_x[2] = req.a_im; mul_y[2] = ONE;
                mul_x[4] = req.a_re; mul_y[4] = req.a_re;
                mul_x[5] = req.a_im; mul_y[5] = req.a_im;
                cls.neg    = 4'b0100;
                cls.shift  = SH_2FB;
                cls.is_div = 1'b1;
            end
            OP_CONJ, OP_NEG:
            begin
                mul_x[0] = req.a_re; mul_y[0] = ONE;
                mul_x[2] = req.a_im; mul_y[2] = ONE;
                cls.neg  = (req.req_type == OP_NEG) ? 4'b0101 : 4'b0100;
            end
            OP_MULREAL:
            begin
                mul_x[0] = req.a_re; mul_y[0] = req.b_re;
                mul_x[2] = req.a_im; mul_y[2] = req.b_re;
                cls.shift = SH_FB;
            end
            OP_MULIMAG:
            begin
                mul_x[0] = req.a_im; mul_y[0] = req.b_re;
                mul_x[2] = req.a_re; mul_y[2] = req.b_re;
                cls.neg   = 4'b0001;
                cls.shift = SH_FB;
            end
            OP_DIVREAL:
            begin
                mul_x[0] = req.a_re; mul_y[0] = ONE;
                mul_x[2] = req.a_im; mul_y[2] = ONE;
                mul_x[4] = req.b_re; mul_y[4] = ONE;
                cls.shift  = SH_FB;
                cls.is_div = 1'b1;
            end
            OP_DIVIMAG:
            begin
                mul_x[0] = req.a_im; mul_y[0] = ONE;
                mul_x[2] = req.a_re; mul_y[2] = ONE;
                mul_x[4] = req.b_re; mul_y[4] = ONE;
                cls.neg    = 4'b0100;
                cls.shift  = SH_FB;
                cls.is_div = 1'b1;
            end
            default:
            begin
                cls.is_div = 1'b0;
            end
        endcase
    end

endmodule

### rtl/cau_queue.sv
// small register queue between front end and back end
// depends on cau_pkg and the assertion macro header
`include "complex_arithmetic_unit_defines.svh"
module cau_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = cau_pkg::QUEUE_DEPTH
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             full,
    output logic             not_empty
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] data_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;

    assign full      = (count_reg == CW'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign rdata     = data_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            data_reg[wr_ptr_reg] <= wdata;
        end
    end

    `CAU_ASSERT_IMPLY(a_no_push_full, clk, rst_n, full, !push)
    `CAU_ASSERT_IMPLY(a_no_pop_empty, clk, rst_n, count_reg == '0, !pop)
    `CAU_ASSERT_NEXT(a_count_up, clk, rst_n, push && !pop, count_reg == $past(count_reg) + 1'b1)

endmodule

### rtl/cau_back.sv
// back end: multipliers, sums, pipelined restoring divider, saturation, output register
// depends on cau_pkg, cau_if and the assertion macro header
`include "complex_arithmetic_unit_defines.svh"
module cau_back #(
    parameter int DATA_WIDTH = cau_pkg::DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = cau_pkg::FRAC_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          q_valid,
    output logic                          q_pop,
    input  cau_pkg::cls_t                 cls,
    input  logic signed [DATA_WIDTH-1:0]  mul_x [cau_pkg::NUM_MUL],
    input  logic signed [DATA_WIDTH-1:0]  mul_y [cau_pkg::NUM_MUL],
    cau_rsp_if.source                     rsp
);
    import cau_pkg::*;

    localparam int DW  = DATA_WIDTH;
    localparam int PW  = 2 * DW;
    localparam int SW  = 2 * DW + 1;
    localparam int SHW = (2 * FRAC_BITS > DW) ? 2 * FRAC_BITS : DW;
    localparam int W   = SW + SHW;

    localparam logic [SW-1:0] HALF  = SW'(1) << (DW - 1);
    localparam logic [SW-1:0] LIM_P = HALF - SW'(1);
    localparam logic [DW-1:0] MAXV  = LIM_P[DW-1:0];
    localparam logic [DW-1:0] MINV  = HALF[DW-1:0];

    typedef struct packed {
        logic          is_div;
        logic          dz;
        logic          neg_re;
        logic          neg_im;
        logic          flag_re;
        logic          flag_im;
        logic [W-1:0]  rem_re;
        logic [W-1:0]  rem_im;
        logic [W-1:0]  dmag;
        logic [DW-1:0] q_re;
        logic [DW-1:0] q_im;
    } dv_t;

    function automatic logic [DW:0] sat_pack(input logic neg, input logic [SW-1:0] m);
        logic [SW-1:0] lim;
        logic [DW-1:0] v;
        logic          s;
        lim = neg ? HALF : LIM_P;
        s   = (m > lim);
        v   = s ? lim[DW-1:0] : m[DW-1:0];
        return {s, neg ? -v : v};
    endfunction

    logic                 en;
    logic                 v1_reg;
    cls_t                 cls1_reg;
    logic signed [PW-1:0] p_reg [NUM_MUL];
    logic                 v2_reg;
    cls_t                 cls2_reg;
    logic signed [SW-1:0] re_reg, im_reg, den_reg;
    logic signed [SW-1:0] re_next, im_next, den_next;
    logic signed [SW-1:0] t_next [NUM_MUL];
    logic [SW-1:0]        mag_re, mag_im, mag_den, shr_re, shr_im;
    logic [W-1:0]         num_re, num_im, dlim;
    logic [DW:0]          pk_re, pk_im, fin_re, fin_im;
    logic                 dvv_reg [DW+1];
    dv_t                  dv_reg  [DW+1];
    dv_t                  dv_next [DW+1];
    logic                 rsp_valid_reg;
    logic [DW-1:0]        res_re_reg, res_im_reg;
    status_t              status_reg, status_next;

    assign en    = !rsp_valid_reg || rsp.ready;
    assign q_pop = en && q_valid;

    // sums of signed product terms
    always_comb
    begin
        for (int k = 0; k < NUM_MUL; k++)
        begin
            t_next[k] = SW'(p_reg[k]);
        end
        for (int k = 0; k < 4; k++)
        begin
            if (cls1_reg.neg[k])
            begin
                t_next[k] = -SW'(p_reg[k]);
            end
        end
        re_next  = t_next[0] + t_next[1];
        im_next  = t_next[2] + t_next[3];
        den_next = t_next[4] + t_next[5];
    end

    // magnitudes, plain saturation and divider setup
    always_comb
    begin
        mag_re  = re_reg[SW-1]  ? SW'(-re_reg)  : SW'(re_reg);
        mag_im  = im_reg[SW-1]  ? SW'(-im_reg)  : SW'(im_reg);
        mag_den = den_reg[SW-1] ? SW'(-den_reg) : SW'(den_reg);
        case (cls2_reg.shift)
            SH_FB:
            begin
                shr_re = mag_re >> FRAC_BITS;
                shr_im = mag_im >> FRAC_BITS;
            end
            default:
            begin
                shr_re = mag_re;
                shr_im = mag_im;
            end
        endcase
        pk_re = sat_pack(re_reg[SW-1], shr_re);
        pk_im = sat_pack(im_reg[SW-1], shr_im);
        if (cls2_reg.shift == SH_2FB)
        begin
            num_re = W'(mag_re) << (2 * FRAC_BITS);
            num_im = W'(mag_im) << (2 * FRAC_BITS);
        end
        else
        begin
            num_re = W'(mag_re) << FRAC_BITS;
            num_im = W'(mag_im) << FRAC_BITS;
        end
        dlim = W'(mag_den) << DW;

        dv_next[0].is_div = cls2_reg.is_div;
        dv_next[0].dz     = cls2_reg.is_div && (den_reg == '0);
        dv_next[0].dmag   = W'(mag_den);
        dv_next[0].rem_re = num_re;
        dv_next[0].rem_im = num_im;
        if (cls2_reg.is_div)
        begin
            dv_next[0].neg_re  = re_reg[SW-1] ^ den_reg[SW-1];
            dv_next[0].neg_im  = im_reg[SW-1] ^ den_reg[SW-1];
            dv_next[0].flag_re = (num_re >= dlim);
            dv_next[0].flag_im = (num_im >= dlim);
            dv_next[0].q_re    = '0;
            dv_next[0].q_im    = '0;
        end
        else
        begin
            dv_next[0].neg_re  = re_reg[SW-1];
            dv_next[0].neg_im  = im_reg[SW-1];
            dv_next[0].flag_re = pk_re[DW];
            dv_next[0].flag_im = pk_im[DW];
            dv_next[0].q_re    = pk_re[DW-1:0];
            dv_next[0].q_im    = pk_im[DW-1:0];
        end
    end

    // one quotient bit per stage, most significant first
    for (genvar k = 0; k < DW; k++)
    begin : g_div
        localparam int BI = DW - 1 - k;
        logic [W-1:0] dsh;
        logic         ge_re, ge_im;

        always_comb
        begin
            dsh           = dv_reg[k].dmag << BI;
            ge_re         = (dv_reg[k].rem_re >= dsh);
            ge_im         = (dv_reg[k].rem_im >= dsh);
            dv_next[k+1]  = dv_reg[k];
            if (dv_reg[k].is_div)
            begin
                if (ge_re)
                begin
                    dv_next[k+1].rem_re   = dv_reg[k].rem_re - dsh;
                    dv_next[k+1].q_re[BI] = 1'b1;
                end
                if (ge_im)
                begin
                    dv_next[k+1].rem_im   = dv_reg[k].rem_im - dsh;
                    dv_next[k+1].q_im[BI] = 1'b1;
                end
            end
        end
    end

    // final saturation and status
    always_comb
    begin
        if (dv_reg[DW].is_div)
        begin
            fin_re = sat_pack(dv_reg[DW].neg_re,
                              dv_reg[DW].flag_re ? '1 : SW'(dv_reg[DW].q_re));
            fin_im = sat_pack(dv_reg[DW].neg_im,
                              dv_reg[DW].flag_im ? '1 : SW'(dv_reg[DW].q_im));
        end
        else
        begin
            fin_re = {dv_reg[DW].flag_re, dv_reg[DW].q_re};
            fin_im = {dv_reg[DW].flag_im, dv_reg[DW].q_im};
        end
        if (dv_reg[DW].dz)
        begin
            status_next = ST_DZ;
        end
        else if (fin_re[DW] || fin_im[DW])
        begin
            status_next = ST_SAT;
        end
        else
        begin
            status_next = ST_OK;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            rsp_valid_reg <= 1'b0;
            for (int k = 0; k <= DW; k++)
            begin
                dvv_reg[k] <= 1'b0;
            end
        end
        else if (en)
        begin
            v1_reg        <= q_valid;
            v2_reg        <= v1_reg;
            dvv_reg[0]    <= v2_reg;
            for (int k = 0; k < DW; k++)
            begin
                dvv_reg[k+1] <= dvv_reg[k];
            end
            rsp_valid_reg <= dvv_reg[DW];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cls1_reg <= cls;
            for (int k = 0; k < NUM_MUL; k++)
            begin
                p_reg[k] <= PW'(mul_x[k] * mul_y[k]);
            end
            cls2_reg <= cls1_reg;
            re_reg   <= re_next;
            im_reg   <= im_next;
            den_reg  <= den_next;
            for (int k = 0; k <= DW; k++)
            begin
                dv_reg[k] <= dv_next[k];
            end
            res_re_reg <= dv_reg[DW].dz ? '0 : fin_re[DW-1:0];
            res_im_reg <= dv_reg[DW].dz ? '0 : fin_im[DW-1:0];
            status_reg <= status_next;
        end
    end

    assign rsp.valid  = rsp_valid_reg;
    assign rsp.res_re = res_re_reg;
    assign rsp.res_im = res_im_reg;
    assign rsp.status = status_reg;

    `CAU_ASSERT_IMPLY(a_dz_zero, clk, rst_n, rsp_valid_reg && status_reg == ST_DZ, res_re_reg == '0 && res_im_reg == '0)
    `CAU_ASSERT_IMPLY(a_sat_edge, clk, rst_n, rsp_valid_reg && status_reg == ST_SAT, res_re_reg == MAXV || res_re_reg == MINV || res_im_reg == MAXV || res_im_reg == MINV)
    `CAU_ASSERT_NEXT(a_last_to_out, clk, rst_n, en && dvv_reg[DW], rsp_valid_reg)

endmodule

### rtl/complex_arithmetic_unit.sv
// top level of the complex arithmetic unit: front end, queue, back end
// depends on cau_pkg, cau_if, cau_front, cau_queue and cau_back
//
// channel   dir   payload                                   handshake
// req       in    req_type, a_re, a_im, b_re, b_im          valid / ready
// rsp       out   res_re, res_im, status                    valid / ready
//
// one transfer per cycle sustained on both channels, every operation, while rsp.ready stays high
// a request passes the queue, the product and sum registers, the divider stages and the output register,
// and every item passes the divider pipeline of one quotient bit per stage
// reset clears the queue and all stage valid bits; no clearing pass
// a stalled result freezes the back end; the queue then fills and req.ready drops
module complex_arithmetic_unit #(
    parameter int DATA_WIDTH = cau_pkg::DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = cau_pkg::FRAC_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    cau_req_if.sink     req,
    cau_rsp_if.source   rsp
);
    import cau_pkg::*;

    localparam int CW = $bits(cls_t);
    localparam int LW = CW + 2 * NUM_MUL * DATA_WIDTH;

    logic                         push, pop, full, not_empty;
    cls_t                         f_cls, b_cls;
    logic signed [DATA_WIDTH-1:0] f_x [NUM_MUL];
    logic signed [DATA_WIDTH-1:0] f_y [NUM_MUL];
    logic signed [DATA_WIDTH-1:0] b_x [NUM_MUL];
    logic signed [DATA_WIDTH-1:0] b_y [NUM_MUL];
    logic [LW-1:0]                q_wdata, q_rdata;

    cau_front #(.DATA_WIDTH(DATA_WIDTH)) u_front (
        .req    (req),
        .q_full (full),
        .push   (push),
        .cls    (f_cls),
        .mul_x  (f_x),
        .mul_y  (f_y)
    );

    always_comb
    begin
        q_wdata[CW-1:0] = f_cls;
        for (int k = 0; k < NUM_MUL; k++)
        begin
            q_wdata[CW + k * DATA_WIDTH +: DATA_WIDTH]             = f_x[k];
            q_wdata[CW + (NUM_MUL + k) * DATA_WIDTH +: DATA_WIDTH] = f_y[k];
        end
    end

    cau_queue #(.WIDTH(LW), .DEPTH(QUEUE_DEPTH)) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .wdata     (q_wdata),
        .pop       (pop),
        .rdata     (q_rdata),
        .full      (full),
        .not_empty (not_empty)
    );

    always_comb
    begin
        b_cls = cls_t'(q_rdata[CW-1:0]);
        for (int k = 0; k < NUM_MUL; k++)
        begin
            b_x[k] = q_rdata[CW + k * DATA_WIDTH +: DATA_WIDTH];
            b_y[k] = q_rdata[CW + (NUM_MUL + k) * DATA_WIDTH +: DATA_WIDTH];
        end
    end

    cau_back #(.DATA_WIDTH(DATA_WIDTH), .FRAC_BITS(FRAC_BITS)) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (not_empty),
        .q_pop   (pop),
        .cls     (b_cls),
        .mul_x   (b_x),
        .mul_y   (b_y),
        .rsp     (rsp)
    );

endmodule
